@@ rtl/mm_pkg.sv @@
`timescale 1ns / 1ps

package mm_pkg;

    // Field widths fixed by the item formats
    localparam int ACTION_W  = 2;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 40;

    // Default matrix dimension limit
    localparam int MAX_DIM_DEF = 8;

    // Action codes carried in the input tuser
    localparam logic [ACTION_W-1:0] ACT_WR_A    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WR_B    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    // Dimension register reset value
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             wr_a;       // write accepted element into A
        logic             wr_b;       // write accepted element into B
        logic             rd_en;      // read one A/B pair for the dot product
        logic             first;      // first term of a product element
        logic             acc_last;   // last term of a product element
        logic             elem_last;  // final element of the product matrix
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
    } mm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic busy;  // terms or a finished element still inside the datapath
    } mm_status_t;

endpackage

@@ rtl/matrix_multiply_core.sv @@
// Fixed-point matrix multiply, A (rows_a x inner_len) times B (inner_len x cols_b).
// Load items: one per cycle while no compute is running, written to the A or B RAM at
// the accepting edge. Compute item: product elements are worked out one at a time, each
// by one RAM read per term, then multiply, accumulate and output stages; no input is
// taken until the final element has moved to the output register.
// Reset (async, active low) clears control and sets all dimensions to 8; RAMs are not cleared.
`timescale 1ns / 1ps

module matrix_multiply_core #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration writes
    input  logic                          cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]      cfg_data,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mm_pkg::TDATA_W-1:0]    s_tdata,   // row_index, col_index, element_value, zero pad
    input  logic [mm_pkg::ACTION_W-1:0]   s_tuser,   // action
    // Result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mm_pkg::TDATA_W-1:0]    m_tdata,   // out_row, out_col, product_value, zero pad
    output logic                          m_tlast,   // last_element
    output logic                          m_tuser    // saturated
);

    import mm_pkg::*;

    localparam int PAD_W = TDATA_W - 2 * IDX_W - DATA_W;

    mm_cmd_t           cmd;
    mm_status_t        status;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic [DATA_W-1:0] out_value;

    // Controller
    mm_ctrl #(
        .MAX_DIM(MAX_DIM)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_action(s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    // Datapath
    mm_dp #(
        .MAX_DIM(MAX_DIM)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .wr_row   (s_tdata[IDX_W-1:0]),
        .wr_col   (s_tdata[2*IDX_W-1:IDX_W]),
        .wr_value (s_tdata[2*IDX_W+DATA_W-1:2*IDX_W]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_row  (out_row),
        .out_col  (out_col),
        .out_value(out_value),
        .out_last (m_tlast),
        .out_sat  (m_tuser)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_value, out_col, out_row};

endmodule

@@ rtl/mm_ram.sv @@
`timescale 1ns / 1ps

module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mm_dp.sv @@
`timescale 1ns / 1ps

module mm_dp #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mm_pkg::mm_cmd_t            cmd,
    output mm_pkg::mm_status_t         status,
    input  logic [mm_pkg::IDX_W-1:0]   wr_row,
    input  logic [mm_pkg::IDX_W-1:0]   wr_col,
    input  logic [mm_pkg::DATA_W-1:0]  wr_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mm_pkg::IDX_W-1:0]   out_row,
    output logic [mm_pkg::IDX_W-1:0]   out_col,
    output logic [mm_pkg::DATA_W-1:0]  out_value,
    output logic                       out_last,
    output logic                       out_sat
);

    import mm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 2 * DATA_W;
    localparam int SH_W   = PROD_W - 16;
    localparam int ACC_W  = SH_W + $clog2(MAX_DIM);

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
    endfunction

    logic              wr_ok;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [DATA_W-1:0] a_q;
    logic [DATA_W-1:0] b_q;

    // Stage 1: tags travelling with the RAM read
    logic             v1_reg;
    logic             first1_reg;
    logic             acclast1_reg;
    logic             elast1_reg;
    logic [IDX_W-1:0] row1_reg;
    logic [IDX_W-1:0] col1_reg;

    // Stage 2: product
    logic                     v2_reg;
    logic                     first2_reg;
    logic                     acclast2_reg;
    logic                     elast2_reg;
    logic [IDX_W-1:0]         row2_reg;
    logic [IDX_W-1:0]         col2_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Accumulator and finished element
    logic signed [SH_W-1:0]  sh;
    logic signed [ACC_W-1:0] sh_ext;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    res_pending_reg;
    logic                    res_last_reg;
    logic [IDX_W-1:0]        res_row_reg;
    logic [IDX_W-1:0]        res_col_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_load;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;
    logic              out_sat_reg;

    logic              sat;
    logic [DATA_W-1:0] sat_value;

    // Load address, writes beyond the store are dropped
    assign wr_ok = ({1'b0, wr_row} < (IDX_W + 1)'(MAX_DIM))
                && ({1'b0, wr_col} < (IDX_W + 1)'(MAX_DIM));
    assign waddr = elem_addr(wr_row, wr_col);

    assign addr_a = cmd.wr_a ? waddr : elem_addr(cmd.row, cmd.k);
    assign addr_b = cmd.wr_b ? waddr : elem_addr(cmd.k, cmd.col);

    mm_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram_a (
        .clk  (clk),
        .we   (cmd.wr_a && wr_ok),
        .addr (addr_a),
        .wdata(wr_value),
        .rdata(a_q)
    );

    mm_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram_b (
        .clk  (clk),
        .we   (cmd.wr_b && wr_ok),
        .addr (addr_b),
        .wdata(wr_value),
        .rdata(b_q)
    );

    // Floor of the Q16.16 product, sign extended to the accumulator
    assign sh     = prod_reg[PROD_W-1:16];
    assign sh_ext = {{(ACC_W - SH_W){sh[SH_W-1]}}, sh};

    // Clip to the signed 32-bit range
    assign sat       = !((&acc_reg[ACC_W-1:DATA_W-1]) || (~|acc_reg[ACC_W-1:DATA_W-1]));
    assign sat_value = acc_reg[ACC_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                        : {1'b0, {(DATA_W - 1){1'b1}}};

    assign out_load = res_pending_reg && (!out_valid_reg || out_ready);

    // Control flags of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            res_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            if (v2_reg && acclast2_reg)
            begin
                res_pending_reg <= 1'b1;
            end
            else if (out_load)
            begin
                res_pending_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the pipeline
    always_ff @(posedge clk)
    begin
        first1_reg   <= cmd.first;
        acclast1_reg <= cmd.acc_last;
        elast1_reg   <= cmd.elem_last;
        row1_reg     <= cmd.row;
        col1_reg     <= cmd.col;

        first2_reg   <= first1_reg;
        acclast2_reg <= acclast1_reg;
        elast2_reg   <= elast1_reg;
        row2_reg     <= row1_reg;
        col2_reg     <= col1_reg;
        prod_reg     <= $signed(a_q) * $signed(b_q);

        if (v2_reg)
        begin
            acc_reg <= first2_reg ? sh_ext : acc_reg + sh_ext;
        end
        if (v2_reg && acclast2_reg)
        begin
            res_last_reg <= elast2_reg;
            res_row_reg  <= row2_reg;
            res_col_reg  <= col2_reg;
        end

        if (out_load)
        begin
            out_row_reg   <= res_row_reg;
            out_col_reg   <= res_col_reg;
            out_value_reg <= sat ? sat_value : acc_reg[DATA_W-1:0];
            out_last_reg  <= res_last_reg;
            out_sat_reg   <= sat;
        end
    end

    assign status.busy = v1_reg || v2_reg || res_pending_reg;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_sat   = out_sat_reg;

`ifndef SYNTHESIS
    // A finished element never lands on one still waiting for the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && acclast2_reg) |-> !res_pending_reg)
        else $error("finished element overwrites a pending one");

    // A waiting element reaches an empty output register at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_pending_reg && !out_valid_reg) |=> (out_valid_reg && !res_pending_reg))
        else $error("pending element not moved to the output");
`endif

endmodule

@@ rtl/mm_ctrl.sv @@
`timescale 1ns / 1ps

module mm_ctrl #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mm_pkg::ACTION_W-1:0]   in_action,
    output mm_pkg::mm_cmd_t               cmd,
    input  mm_pkg::mm_status_t            status
);

    import mm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // Highest index for a dimension register, out-of-range values clamped
    function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] dim);
        logic [IDX_W-1:0] r;
        if (dim == '0)
        begin
            r = '0;
        end
        else if (dim > DIM_W'(MAX_DIM))
        begin
            r = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = IDX_W'(dim - 1'b1);
        end
        return r;
    endfunction

    state_t           state_reg;
    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] inner_len_reg;
    logic [DIM_W-1:0] cols_b_reg;
    logic [IDX_W-1:0] nr_last_reg;
    logic [IDX_W-1:0] nk_last_reg;
    logic [IDX_W-1:0] nc_last_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;

    logic accept;
    logic elem_last;
    logic term_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign elem_last = (i_reg == nr_last_reg) && (j_reg == nc_last_reg);
    assign term_last = (k_reg == nk_last_reg);

    // Commands to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.wr_a      = accept && (in_action == ACT_WR_A);
        cmd.wr_b      = accept && (in_action == ACT_WR_B);
        cmd.rd_en     = (state_reg == ST_ISSUE);
        cmd.first     = (k_reg == '0);
        cmd.acc_last  = term_last;
        cmd.elem_last = elem_last;
        cmd.row       = i_reg;
        cmd.col       = j_reg;
        cmd.k         = k_reg;
    end

    // Sequencer over rows, columns and terms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_a_reg    <= DIM_RESET;
            inner_len_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
            nr_last_reg   <= '0;
            nk_last_reg   <= '0;
            nc_last_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                    CFG_INNER_LEN: inner_len_reg <= cfg_data;
                    CFG_COLS_B:    cols_b_reg    <= cfg_data;
                    default:       ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (in_action == ACT_COMPUTE))
                    begin
                        nr_last_reg <= last_idx(rows_a_reg);
                        nk_last_reg <= last_idx(inner_len_reg);
                        nc_last_reg <= last_idx(cols_b_reg);
                        i_reg       <= '0;
                        j_reg       <= '0;
                        k_reg       <= '0;
                        state_reg   <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (term_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (!status.busy)
                    begin
                        if (elem_last)
                        begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            if (j_reg == nc_last_reg)
                            begin
                                j_reg <= '0;
                                i_reg <= i_reg + 1'b1;
                            end
                            else
                            begin
                                j_reg <= j_reg + 1'b1;
                            end
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Datapath is empty whenever new items are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !status.busy)
        else $error("datapath busy while idle");

    // Indexes stay within the latched dimensions
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ((k_reg <= nk_last_reg) && (j_reg <= nc_last_reg)
                                    && (i_reg <= nr_last_reg)))
        else $error("index beyond matrix dimension");
`endif

endmodule

@@ bench/mm_product_checker.sv @@
`timescale 1ns / 1ps

// Watches the configuration port and both item channels, keeps its own copy of
// the A/B element stores and the dimension registers, and checks every product
// element that leaves the core against the expected value in arrival order.
module mm_product_checker
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // row_index, col_index, element_value, zero pad
    input  logic [ACTION_W-1:0]  s_tuser,   // action
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [TDATA_W-1:0]   m_tdata,   // out_row, out_col, product_value, zero pad
    input  logic                 m_tlast,
    input  logic                 m_tuser,
    output int                   mismatches,
    output int                   pending,
    output int                   elems_checked,
    output int                   elems_saturated
);

    localparam longint Q_MAX = 2147483647;
    localparam longint Q_MIN = -longint'(2147483647) - 1;

    typedef struct {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
        logic              sat;
    } prod_elem_t;

    prod_elem_t        expected_elems[$];
    logic [DATA_W-1:0] a_store[MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0] b_store[MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]  dim_rows;
    logic [DIM_W-1:0]  dim_inner;
    logic [DIM_W-1:0]  dim_cols;

    // A zero dimension behaves as one, anything past the store size as the maximum
    function automatic int clamp_dim(input logic [DIM_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIM)
            return MAX_DIM;
        return int'(raw);
    endfunction

    // Queue every element of A*B, row-major, with saturation to 32 bits
    task automatic queue_product();
        int         nr;
        int         nk;
        int         nc;
        longint     acc;
        longint     term;
        prod_elem_t e;
        nr = clamp_dim(dim_rows);
        nk = clamp_dim(dim_inner);
        nc = clamp_dim(dim_cols);
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                acc = 0;
                for (int k = 0; k < nk; k++)
                begin
                    term = longint'(signed'(a_store[i*MAX_DIM+k]))
                         * longint'(signed'(b_store[k*MAX_DIM+j]));
                    acc += term >>> 16;     // floor shift
                end
                e.sat = 1'b0;
                if (acc > Q_MAX)
                begin
                    acc   = Q_MAX;
                    e.sat = 1'b1;
                end
                else if (acc < Q_MIN)
                begin
                    acc   = Q_MIN;
                    e.sat = 1'b1;
                end
                e.row   = IDX_W'(i);
                e.col   = IDX_W'(j);
                e.value = acc[DATA_W-1:0];
                e.last  = (i == nr - 1) && (j == nc - 1);
                expected_elems.push_back(e);
            end
        end
    endtask

    // Compare one accepted result item with the oldest expectation
    task automatic check_result();
        prod_elem_t want;
        prod_elem_t got;
        got.row   = m_tdata[IDX_W-1:0];
        got.col   = m_tdata[2*IDX_W-1:IDX_W];
        got.value = m_tdata[2*IDX_W +: DATA_W];
        got.last  = m_tlast;
        got.sat   = m_tuser;
        elems_checked++;
        if (got.sat)
            elems_saturated++;
        if (expected_elems.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: unexpected element row %0d col %0d value %h last %b sat %b",
                         $realtime, got.row, got.col, got.value, got.last, got.sat);
            return;
        end
        want = expected_elems.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.value !== want.value
            || got.last !== want.last || got.sat !== want.sat)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t mismatch: expected row %0d col %0d value %h last %b sat %b",
                         $realtime, want.row, want.col, want.value, want.last, want.sat);
                $display("%0t           actual   row %0d col %0d value %h last %b sat %b",
                         $realtime, got.row, got.col, got.value, got.last, got.sat);
            end
        end
    endtask

    // Element stores are left alone on reset: they are undefined until written
    always @(posedge clk or negedge rst_n)
    begin
        logic [IDX_W-1:0] wr_row;
        logic [IDX_W-1:0] wr_col;
        if (!rst_n)
        begin
            dim_rows        = DIM_RESET;
            dim_inner       = DIM_RESET;
            dim_cols        = DIM_RESET;
            expected_elems.delete();
            mismatches      = 0;
            elems_checked   = 0;
            elems_saturated = 0;
            pending         = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROWS_A:    dim_rows  = cfg_data;
                    CFG_INNER_LEN: dim_inner = cfg_data;
                    CFG_COLS_B:    dim_cols  = cfg_data;
                    default:       ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                wr_row = s_tdata[IDX_W-1:0];
                wr_col = s_tdata[2*IDX_W-1:IDX_W];
                case (s_tuser)
                    ACT_WR_A:
                        if (wr_row < MAX_DIM && wr_col < MAX_DIM)
                            a_store[wr_row*MAX_DIM+wr_col] = s_tdata[2*IDX_W +: DATA_W];
                    ACT_WR_B:
                        if (wr_row < MAX_DIM && wr_col < MAX_DIM)
                            b_store[wr_row*MAX_DIM+wr_col] = s_tdata[2*IDX_W +: DATA_W];
                    ACT_COMPUTE:
                        queue_product();
                    default:       ;   // unused action, nothing happens
                endcase
            end

            pending = expected_elems.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import mm_pkg::*;

    localparam int                  DIM        = MAX_DIM_DEF;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int                  NUM_PHASES = 8;
    localparam int                  PHASE_ITEMS = 8;
    localparam int                  LONG_HOLD  = 400;
    localparam int                  SETTLE     = 2 * (DIM + 4);

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic [ACTION_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    int mismatch_count;
    int pending_count;
    int elems_checked;
    int elems_saturated;

    // Stimulus-side state
    int idle_pct;
    int stall_pct;
    int hold_serial;
    int cur_rows;
    int cur_inner;
    int cur_cols;
    int items_sent;
    int computes_sent;
    bit written_a[DIM*DIM];
    bit written_b[DIM*DIM];

    matrix_multiply_core #(.MAX_DIM(DIM)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    mm_product_checker #(.MAX_DIM(DIM)) u_product_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .mismatches      (mismatch_count),
        .pending         (pending_count),
        .elems_checked   (elems_checked),
        .elems_saturated (elems_saturated)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Safety net
    initial
    begin
        #20_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is requested
    initial
    begin
        int hold_left;
        int hold_seen;
        m_tready  = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_serial != hold_seen)
            begin
                hold_seen = hold_serial;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > DIM)
            return DIM;
        return int'(raw);
    endfunction

    // Mostly full-range values, with extremes and small Q16.16 numbers mixed in
    function automatic logic [DATA_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return $urandom;
        if (pick < 70)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0001_0000;
            endcase
        end
        return 32'($urandom_range(0, 524288)) - 32'd262144;
    endfunction

    // Offer one item and hold it until the core takes it
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(TDATA_W-DATA_W-2*IDX_W){1'b0}}, val, col, row};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        case (act)
            ACT_WR_A:    written_a[int'(row)*DIM + int'(col)] = 1'b1;
            ACT_WR_B:    written_b[int'(row)*DIM + int'(col)] = 1'b1;
            ACT_COMPUTE: computes_sent++;
            default:     ;
        endcase
    endtask

    // Wait for every expected element, then let any trailing work drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                            input logic [DIM_W-1:0] cols);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROWS_A;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= CFG_INNER_LEN;
        cfg_data  <= inner;
        @(posedge clk);
        cfg_index <= CFG_COLS_B;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_rows  = eff_dim(rows);
        cur_inner = eff_dim(inner);
        cur_cols  = eff_dim(cols);
    endtask

    // Fill any element that the next compute would read but was never written
    task automatic fill_unwritten();
        for (int i = 0; i < cur_rows; i++)
            for (int k = 0; k < cur_inner; k++)
                if (!written_a[i*DIM+k])
                    send_item(ACT_WR_A, IDX_W'(i), IDX_W'(k), rand_value());
        for (int k = 0; k < cur_inner; k++)
            for (int j = 0; j < cur_cols; j++)
                if (!written_b[k*DIM+j])
                    send_item(ACT_WR_B, IDX_W'(k), IDX_W'(j), rand_value());
    endtask

    task automatic send_compute();
        fill_unwritten();
        send_item(ACT_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    endtask

    // One random item; loads mostly land inside the active dimensions
    task automatic random_item();
        int               pick;
        bit               inside_dims;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        pick        = $urandom_range(0, 99);
        inside_dims = ($urandom_range(0, 99) < 80);
        if (pick < 45)
        begin
            row = inside_dims ? IDX_W'($urandom_range(0, cur_rows - 1)) : IDX_W'($urandom);
            col = inside_dims ? IDX_W'($urandom_range(0, cur_inner - 1)) : IDX_W'($urandom);
            send_item(ACT_WR_A, row, col, rand_value());
        end
        else if (pick < 82)
        begin
            row = inside_dims ? IDX_W'($urandom_range(0, cur_inner - 1)) : IDX_W'($urandom);
            col = inside_dims ? IDX_W'($urandom_range(0, cur_cols - 1)) : IDX_W'($urandom);
            send_item(ACT_WR_B, row, col, rand_value());
        end
        else if (pick < 95)
            send_compute();
        else
            send_item(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    endtask

    // Dimension settings per phase, raw register values including out-of-range ones
    task automatic phase_dims(input int p, output logic [DIM_W-1:0] rows,
                              output logic [DIM_W-1:0] inner, output logic [DIM_W-1:0] cols);
        case (p)
            0:       begin rows = 4'd3;  inner = 4'd2;  cols = 4'd4; end
            1:       begin rows = 4'd0;  inner = 4'd15; cols = 4'd1; end
            2:       begin rows = 4'd8;  inner = 4'd1;  cols = 4'd8; end
            3:       begin rows = 4'd2;  inner = 4'd5;  cols = 4'd1; end
            4:       begin rows = 4'd9;  inner = 4'd1;  cols = 4'd0; end
            5:       begin rows = 4'd4;  inner = 4'd3;  cols = 4'd7; end
            6:       begin rows = 4'd2;  inner = 4'd7;  cols = 4'd2; end
            default: begin rows = 4'd5;  inner = 4'd4;  cols = 4'd3; end
        endcase
    endtask

    // Idle pattern: none, sender gaps, receiver stalls, both
    task automatic set_idling(input int mode);
        case (mode % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 73; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 37; stall_pct = 37; end
        endcase
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] cols;
        int               drain;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ROWS_A;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ACT_WR_A;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_serial   = 0;
        items_sent    = 0;
        computes_sent = 0;
        cur_rows      = DIM;
        cur_inner     = DIM;
        cur_cols      = DIM;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 1x1x1 products at the value extremes
        set_dims(4'd1, 4'd1, 4'd1);
        send_item(ACT_WR_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_item(ACT_WR_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_compute();                                   // positive clip
        send_item(ACT_WR_B, 3'd0, 3'd0, 32'h8000_0000);
        send_compute();                                   // negative clip
        send_item(ACT_WR_A, 3'd0, 3'd0, 32'h8000_0000);
        send_compute();                                   // min times min
        send_item(ACT_WR_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
        send_item(ACT_WR_B, 3'd0, 3'd0, 32'h0000_8000);
        send_compute();                                   // shift rounds towards minus infinity
        send_item(ACT_UNUSED, 3'd0, 3'd0, 32'h0000_0000); // must leave A alone
        send_item(ACT_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_item(ACT_WR_A, 3'd7, 3'd7, 32'h1234_5678);   // outside the active corner
        send_item(ACT_WR_B, 3'd7, 3'd7, 32'hEDCB_A987);
        send_item(ACT_WR_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_item(ACT_WR_B, 3'd0, 3'd0, 32'h0001_0000);
        send_compute();                                   // largest value that still fits
        wait_idle();

        // Random phases over several dimension settings and idle patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            phase_dims(p, rows, inner, cols);
            set_dims(rows, inner, cols);
            set_idling(p);
            if (p == 2)
            begin
                // receiver holds off while the sender keeps offering items
                fill_unwritten();
                hold_serial++;
                send_compute();
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
            send_compute();
            wait_idle();
        end

        s_tvalid <= 1'b0;
        set_idling(0);
        @(posedge clk);
        drain = 0;
        while (pending_count != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE) @(posedge clk);

        $display("tb_top: %0d input items, %0d computes, %0d dimension settings",
                 items_sent, computes_sent, NUM_PHASES + 1);
        $display("tb_top: %0d product elements checked, %0d of them clipped",
                 elems_checked, elems_saturated);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ matrix_multiply_core.f @@
rtl/mm_pkg.sv
rtl/mm_ram.sv
rtl/mm_dp.sv
rtl/mm_ctrl.sv
rtl/matrix_multiply_core.sv
bench/mm_product_checker.sv
bench/tb_top.sv
